// File: rtl/text_console_cursor_engine_defines.svh
// Assertion macros for the text console engine checker.
// Both macros assume a clock named clk and a synchronous reset named rst in scope.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Next-cycle implication, quiet while reset is high.
`define TCCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcce checker: assertion failed");

// Next-cycle implication that is also checked across reset.
`define TCCE_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tcce checker: assertion failed");

`endif

// File: rtl/tcce_pkg.sv
// Shared constants, command codes and helpers for the text console engine.
// No dependencies.
package tcce_pkg;

  localparam int COLUMNS       = 80;
  localparam int ROWS          = 25;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  localparam logic [7:0] TAB_STEP      = 8'd4;
  localparam logic [7:0] BLANK_CHAR    = 8'h20;
  localparam logic [7:0] DEFAULT_COLOR = 8'h07;
  localparam logic [4:0] TOP_ROW_RESET = 5'd6;

  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_TAB = 8'd9;

  typedef enum logic [3:0] {
    CMD_PUT          = 4'd0,
    CMD_PUT_COLOR    = 4'd1,
    CMD_SET_CURSOR   = 4'd2,
    CMD_SET_COLOR    = 4'd3,
    CMD_CLEAR_SCREEN = 4'd4,
    CMD_CLEAR_LINE   = 4'd5,
    CMD_BACKSPACE    = 4'd6,
    CMD_SCROLL       = 4'd7,
    CMD_READ_CELL    = 4'd8
  } cmd_t;

  // Linear cell address; only meaningful for positions inside the grid.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  function automatic logic in_grid(input logic [ROW_W-1:0] r,
                                   input logic [COL_W-1:0] c);
    return ({1'b0, c} < 8'(COLUMNS)) && ({1'b0, r} < 6'(ROWS));
  endfunction

endpackage

// File: rtl/text_console_cursor_engine.sv
// Text console engine: character grid memory, cursor, active color, command sequencer.
// Depends on tcce_pkg.
//
// One command per transfer on the cmd channel, one result per command on the res
// channel. All grid work runs through a single memory port pair (one write, one
// registered read) under a small sequencer, so the command channel stalls while a
// command is in progress. Put, set cursor, set color, backspace and unused codes
// pass through S_EXEC and S_DONE; read cell adds S_READ_WAIT; clear line sweeps
// the COLUMNS cells of one row; clear screen sweeps all ROWS*COLUMNS cells;
// scroll (and a put that scrolls) copies each row below top_row one row up, then
// blanks the last row, or only blanks the last row when top_row is at or past
// the last row. Copies and sweeps move one cell per cycle through the memory
// write port, a sweep holding while the last copy write drains. cmd_stall drops
// in the same cycle that res_valid rises. After reset the grid is cleared by a
// pass over all ROWS*COLUMNS cells during which cmd_stall is high; top_row
// writes are accepted at any time. A finished result sits in an output register,
// so a new command is taken while the previous result still waits on res_stall.
module text_console_cursor_engine (
  input  logic                      clk,
  input  logic                      rst,
  // command channel
  input  logic                      cmd_valid,
  output logic                      cmd_stall,
  input  logic [3:0]                cmd,
  input  logic [7:0]                char_code,
  input  logic [7:0]                color,
  input  logic [tcce_pkg::ROW_W-1:0] row,
  input  logic [tcce_pkg::COL_W-1:0] col,
  // result channel
  output logic                      res_valid,
  input  logic                      res_stall,
  output logic [15:0]               cell_data,
  output logic [tcce_pkg::COL_W-1:0] cursor_col,
  output logic [tcce_pkg::ROW_W-1:0] cursor_row,
  output logic [7:0]                text_color,
  // configuration: top_row register
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [4:0]                top_row
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR_MEM,  // post-reset clearing pass
    S_IDLE,
    S_EXEC,       // decode latched command, single-cell writes, start sweeps
    S_READ_WAIT,  // registered read data arrives
    S_COPY,       // scroll: read row below, write it one row up
    S_SWEEP,      // fill a range of cells with one value
    S_DONE        // publish result when the output register is free
  } state_t;

  state_t state;

  // latched command
  logic [3:0]       cmd_q;
  logic [7:0]       ch_q;
  logic [7:0]       clr_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;

  // architectural state
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [7:0]       act_color;
  logic [4:0]       scroll_top;

  // sweep / copy sequencing
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] fill_end;
  logic [15:0]       fill_data;
  logic [ADDR_W-1:0] src;
  logic              cp_pend;   // copy write comes in the cycle after its read
  logic [ADDR_W-1:0] cp_waddr;
  logic [15:0]       data_q;

  // grid memory
  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // put decode
  logic [7:0] put_clr;
  logic [7:0] pc_a;
  logic [5:0] pr_a;
  logic [7:0] put_col;
  logic [5:0] put_row;
  logic       put_scroll;
  logic       put_wr;

  // backspace decode
  logic [COL_W-1:0] bs_col;
  logic [ROW_W-1:0] bs_row;

  // scroll start
  logic [5:0]        scr_first;
  logic              scr_copy;
  logic [ADDR_W-1:0] scr_src;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    put_clr = (cmd_q == CMD_PUT_COLOR) ? clr_q : act_color;
    put_wr  = 1'b0;
    pc_a    = {1'b0, cur_col};
    pr_a    = {1'b0, cur_row};
    if (ch_q == CHAR_LF) begin
      pc_a = '0;
      pr_a = {1'b0, cur_row} + 6'd1;
    end else if (ch_q == CHAR_CR) begin
      pc_a = '0;
    end else if (ch_q == CHAR_TAB) begin
      pc_a = ({1'b0, cur_col} + TAB_STEP) & ~(TAB_STEP - 8'd1);
    end else begin
      put_wr = in_grid(cur_row, cur_col);
      pc_a   = {1'b0, cur_col} + 8'd1;
    end
    put_col = pc_a;
    put_row = pr_a;
    if (pc_a >= 8'(COLUMNS)) begin
      put_col = '0;
      put_row = pr_a + 6'd1;
    end
    put_scroll = (put_row >= 6'(ROWS));
    if (put_scroll) begin
      put_row = 6'(ROWS - 1);
    end
  end

  always_comb begin
    bs_col = cur_col;
    bs_row = cur_row;
    if (cur_col != '0) begin
      bs_col = cur_col - COL_W'(1);
    end else if (cur_row > scroll_top) begin
      bs_row = cur_row - ROW_W'(1);
      bs_col = COL_W'(COLUMNS - 1);
    end
  end

  assign scr_first = {1'b0, scroll_top} + 6'd1;
  assign scr_copy  = (scr_first < 6'(ROWS));
  assign scr_src   = ADDR_W'(scr_first) * ADDR_W'(COLUMNS);

  // single write port: a pending copy write wins over sweep writes
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cp_waddr;
    mem_wdata = rd_data;
    mem_raddr = (state == S_COPY) ? src : cell_addr(row_q, col_q);
    if (cp_pend) begin
      mem_we = 1'b1;
    end else begin
      case (state)
        S_CLEAR_MEM: begin
          mem_we    = 1'b1;
          mem_waddr = fill_addr;
          mem_wdata = '0;
        end
        S_SWEEP: begin
          mem_we    = 1'b1;
          mem_waddr = fill_addr;
          mem_wdata = fill_data;
        end
        S_EXEC: begin
          if ((cmd_q == CMD_PUT || cmd_q == CMD_PUT_COLOR) && put_wr) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cur_row, cur_col);
            mem_wdata = {put_clr, ch_q};
          end else if (cmd_q == CMD_BACKSPACE && in_grid(bs_row, bs_col)) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(bs_row, bs_col);
            mem_wdata = {act_color, BLANK_CHAR};
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR_MEM;
      fill_addr  <= '0;
      res_valid  <= 1'b0;
      cur_col    <= '0;
      cur_row    <= TOP_ROW_RESET;
      act_color  <= DEFAULT_COLOR;
      scroll_top <= TOP_ROW_RESET;
      cp_pend    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        scroll_top <= top_row;
      end
      cp_pend  <= (state == S_COPY);
      cp_waddr <= src - ADDR_W'(COLUMNS);
      // S_DONE publishes on its own; elsewhere a taken result just drops
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR_MEM: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == ADDR_W'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd;
            ch_q  <= char_code;
            clr_q <= color;
            row_q <= row;
            col_q <= col;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          data_q <= '0;
          case (cmd_q)
            CMD_PUT, CMD_PUT_COLOR, CMD_SCROLL: begin
              if (cmd_q != CMD_SCROLL) begin
                cur_col <= put_col[COL_W-1:0];
                cur_row <= put_row[ROW_W-1:0];
              end
              if (cmd_q == CMD_SCROLL || put_scroll) begin
                fill_data <= {put_clr, BLANK_CHAR};
                if (scr_copy) begin
                  src   <= scr_src;
                  state <= S_COPY;
                end else begin
                  // nothing to move: just blank the last row
                  fill_addr <= ADDR_W'(LAST_ROW_BASE);
                  fill_end  <= ADDR_W'(CELLS - 1);
                  state     <= S_SWEEP;
                end
              end else begin
                state <= S_DONE;
              end
            end
            CMD_SET_CURSOR: begin
              cur_col <= col_q;
              cur_row <= row_q;
              state   <= S_DONE;
            end
            CMD_SET_COLOR: begin
              act_color <= clr_q;
              state     <= S_DONE;
            end
            CMD_CLEAR_SCREEN: begin
              act_color <= clr_q;
              cur_col   <= '0;
              cur_row   <= scroll_top;
              fill_data <= {clr_q, BLANK_CHAR};
              fill_addr <= '0;
              fill_end  <= ADDR_W'(CELLS - 1);
              state     <= S_SWEEP;
            end
            CMD_CLEAR_LINE: begin
              if ({1'b0, row_q} < 6'(ROWS)) begin
                fill_data <= {act_color, BLANK_CHAR};
                fill_addr <= cell_addr(row_q, '0);
                fill_end  <= cell_addr(row_q, COL_W'(COLUMNS - 1));
                state     <= S_SWEEP;
              end else begin
                state <= S_DONE;
              end
            end
            CMD_BACKSPACE: begin
              cur_col <= bs_col;
              cur_row <= bs_row;
              state   <= S_DONE;
            end
            CMD_READ_CELL: begin
              if (in_grid(row_q, col_q)) begin
                state <= S_READ_WAIT;
              end else begin
                state <= S_DONE;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end

        S_READ_WAIT: begin
          data_q <= rd_data;
          state  <= S_DONE;
        end

        S_COPY: begin
          src <= src + ADDR_W'(1);
          if (src == ADDR_W'(CELLS - 1)) begin
            fill_addr <= ADDR_W'(LAST_ROW_BASE);
            fill_end  <= ADDR_W'(CELLS - 1);
            state     <= S_SWEEP;
          end
        end

        S_SWEEP: begin
          // hold while the last copy write drains through the port
          if (!cp_pend) begin
            fill_addr <= fill_addr + ADDR_W'(1);
            if (fill_addr == fill_end) begin
              state <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            cell_data  <= data_q;
            cursor_col <= cur_col;
            cursor_row <= cur_row;
            text_color <= act_color;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/tcce_checker.sv
// Port-level checker for the text console engine, bound to the engine module.
// Depends on text_console_cursor_engine_defines.svh.
`include "text_console_cursor_engine_defines.svh"

module tcce_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_stall,
  input logic        res_valid,
  input logic        res_stall,
  input logic [15:0] cell_data,
  input logic [6:0]  cursor_col,
  input logic [4:0]  cursor_row,
  input logic [7:0]  text_color
);

  // grid clearing pass follows reset
  `TCCE_ASSERT_ALWAYS(a_clear_after_reset, rst, cmd_stall)

  // one command at a time: busy right after a transfer
  `TCCE_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall)

  `TCCE_ASSERT_NEXT(a_res_held, res_valid && res_stall, res_valid)

  `TCCE_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(cell_data) && $stable(cursor_col) && $stable(cursor_row) && $stable(text_color))

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (.*);
